// ----- rtl/fpcv_pkg.sv -----
// Shared types, constants and the CRC-32 byte update for the framed packet validator.
// No dependencies; imported by fpcv_frame_check and the top level.
`default_nettype none

package fpcv_pkg;

    localparam int MAX_PACKET_BYTES = 65536;
    localparam int HEADER_BYTES     = 40;
    localparam int POS_WIDTH        = $clog2(MAX_PACKET_BYTES + 1);
    localparam int HDR_BITS         = HEADER_BYTES * 8;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        STATUS_ACCEPTED     = 2'd0,
        STATUS_TOO_SHORT    = 2'd1,
        STATUS_LEN_MISMATCH = 2'd2,
        STATUS_CRC_MISMATCH = 2'd3
    } frame_status_t;

    typedef struct packed {
        frame_status_t frame_status;
        logic [31:0]   image_width;
        logic [31:0]   image_height;
        logic [31:0]   row_stride;
        logic [7:0]    pixel_format;
        logic [7:0]    camera_number;
        logic [63:0]   time_word;
        logic [63:0]   frame_sequence;
        logic [15:0]   payload_length;
        logic [31:0]   accepted_total;
        logic [31:0]   dropped_total;
        logic [63:0]   byte_total;
    } frame_result_t;

    // Reflected CRC-32 update over one byte, least significant bit first.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/fpcv_frame_check.sv -----
// Per-packet state: header capture, payload CRC, byte position and frame counters.
// Depends on fpcv_pkg; produces the result of a packet on the step that carries its last word.
`default_nettype none

module fpcv_frame_check
    import fpcv_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          step_valid,
    input  wire logic [7:0]    data_byte,
    input  wire logic          last_byte,
    output frame_result_t      result
);

    logic [POS_WIDTH-1:0] pos_reg, pos_next;
    logic [HDR_BITS-1:0]  hdr_reg, hdr_next;
    logic [31:0]          crc_reg, crc_next;
    logic                 oversize_reg, oversize_next;
    logic [31:0]          accepted_reg, accepted_next;
    logic [31:0]          dropped_reg, dropped_next;
    logic [63:0]          bytes_reg, bytes_next;

    logic [POS_WIDTH-1:0] pos_step;
    logic [31:0]          crc_step;
    logic                 oversize_step;
    logic [15:0]          payload;
    logic [31:0]          declared;
    logic [31:0]          check;
    frame_status_t        status;

    always_comb begin
        pos_step      = pos_reg;
        crc_step      = crc_reg;
        oversize_step = oversize_reg;
        hdr_next      = hdr_reg;
        if (pos_reg == POS_WIDTH'(MAX_PACKET_BYTES)) begin
            // Bytes past the size limit are not captured or hashed.
            oversize_step = 1'b1;
        end else begin
            if (pos_reg < POS_WIDTH'(HEADER_BYTES)) begin
                // After the 40th header byte, byte k sits at bits 8k+7:8k.
                hdr_next = {data_byte, hdr_reg[HDR_BITS-1:8]};
            end else begin
                crc_step = crc32_byte(crc_reg, data_byte);
            end
            pos_step = pos_reg + POS_WIDTH'(1);
        end
    end

    assign declared = hdr_next[287:256];
    assign check    = hdr_next[319:288];
    assign payload  = 16'(pos_step - POS_WIDTH'(HEADER_BYTES));

    always_comb begin
        if (pos_step < POS_WIDTH'(HEADER_BYTES)) begin
            status = STATUS_TOO_SHORT;
        end else if (oversize_step || (declared != {16'd0, payload})) begin
            status = STATUS_LEN_MISMATCH;
        end else if ((crc_step ^ CRC_INIT) != check) begin
            status = STATUS_CRC_MISMATCH;
        end else begin
            status = STATUS_ACCEPTED;
        end
    end

    always_comb begin
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        oversize_next = oversize_reg;
        accepted_next = accepted_reg;
        dropped_next  = dropped_reg;
        bytes_next    = bytes_reg;
        if (step_valid) begin
            if (last_byte) begin
                pos_next      = '0;
                crc_next      = CRC_INIT;
                oversize_next = 1'b0;
                if (status == STATUS_ACCEPTED) begin
                    accepted_next = accepted_reg + 32'd1;
                    bytes_next    = bytes_reg + 64'(pos_step);
                end else begin
                    dropped_next = dropped_reg + 32'd1;
                end
            end else begin
                pos_next      = pos_step;
                crc_next      = crc_step;
                oversize_next = oversize_step;
            end
        end
    end

    always_comb begin
        result                = '0;
        result.frame_status   = status;
        result.payload_length = (status == STATUS_TOO_SHORT) ? 16'd0 : payload;
        result.accepted_total = accepted_next;
        result.dropped_total  = dropped_next;
        result.byte_total     = bytes_next;
        if (status == STATUS_ACCEPTED) begin
            result.image_width    = hdr_next[31:0];
            result.image_height   = hdr_next[63:32];
            result.row_stride     = hdr_next[95:64];
            result.pixel_format   = hdr_next[103:96];
            result.camera_number  = hdr_next[111:104];
            result.time_word      = hdr_next[191:128];
            result.frame_sequence = hdr_next[255:192];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            crc_reg      <= CRC_INIT;
            oversize_reg <= 1'b0;
            accepted_reg <= '0;
            dropped_reg  <= '0;
            bytes_reg    <= '0;
        end else begin
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            oversize_reg <= oversize_next;
            accepted_reg <= accepted_next;
            dropped_reg  <= dropped_next;
            bytes_reg    <= bytes_next;
        end
    end

    // A header is only read once all 40 of its bytes have been shifted in.
    always_ff @(posedge aclk) begin
        if (step_valid) begin
            hdr_reg <= hdr_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/framed_packet_crc_validator_top.sv -----
// Top level of the framed packet validator: input word register, checker, result register.
// Depends on fpcv_pkg and fpcv_frame_check.
//
// Usage:
//   The input channel (s_valid/s_ready) carries one packet byte per word, with
//   s_last_byte marking the final byte. The first 40 bytes are the header; the
//   rest is payload that is counted and run through CRC-32.
//   The result channel (m_valid/m_ready) delivers one word per packet: status,
//   header fields (zero on a drop), payload length and the running totals.
//   Throughput is one byte per cycle save for last-byte stalls; the byte-wide
//   CRC update and header capture sit between the input and result registers.
//   m_valid rises once the last byte is loaded into the result register.
//   When the receiver stalls, payload bytes keep flowing; only a last byte
//   waits in the input register until the result register is free.
//   Synchronous active-low reset clears the packet position, CRC register,
//   counters and both valid flags; the block is ready in the next cycle.
`default_nettype none

module framed_packet_crc_validator_top
    import fpcv_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_last_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_frame_status,
    output logic [31:0]      m_image_width,
    output logic [31:0]      m_image_height,
    output logic [31:0]      m_row_stride,
    output logic [7:0]       m_pixel_format,
    output logic [7:0]       m_camera_number,
    output logic [63:0]      m_time_word,
    output logic [63:0]      m_frame_sequence,
    output logic [15:0]      m_payload_length,
    output logic [31:0]      m_accepted_total,
    output logic [31:0]      m_dropped_total,
    output logic [63:0]      m_byte_total
);

    logic          in_valid_reg, in_valid_next;
    logic [7:0]    in_data_reg;
    logic          in_last_reg;
    logic          out_valid_reg, out_valid_next;
    frame_result_t out_reg;
    frame_result_t result;
    logic          advance;
    logic          load_out;

    // Payload words never need the result register, so only a last word can stall.
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign load_out = advance && in_last_reg;
    assign s_ready  = !in_valid_reg || advance;

    fpcv_frame_check u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_valid (advance),
        .data_byte  (in_data_reg),
        .last_byte  (in_last_reg),
        .result     (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
        if (load_out) begin
            out_reg <= result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_frame_status   = out_reg.frame_status;
    assign m_image_width    = out_reg.image_width;
    assign m_image_height   = out_reg.image_height;
    assign m_row_stride     = out_reg.row_stride;
    assign m_pixel_format   = out_reg.pixel_format;
    assign m_camera_number  = out_reg.camera_number;
    assign m_time_word      = out_reg.time_word;
    assign m_frame_sequence = out_reg.frame_sequence;
    assign m_payload_length = out_reg.payload_length;
    assign m_accepted_total = out_reg.accepted_total;
    assign m_dropped_total  = out_reg.dropped_total;
    assign m_byte_total     = out_reg.byte_total;

endmodule

`default_nettype wire

// ----- sim/tb_framed_packet_crc_validator_top.sv -----
// Self-checking testbench for framed_packet_crc_validator_top: byte-stream packets with CRC-32.
// Depends on fpcv_pkg and the validator RTL; a scoreboard class predicts each frame result.
`default_nettype none

module tb_framed_packet_crc_validator_top
    import fpcv_pkg::*;
();

    typedef enum {KIND_GOOD, KIND_CRC_ERR, KIND_LEN_ERR, KIND_SHORT} frame_kind_t;
    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

    // Tracks the packet being received and queues the frame result it must produce.
    class frame_scoreboard;
        int unsigned   position;
        logic [7:0]    header_bytes [HEADER_BYTES];
        logic [31:0]   crc_state;
        bit            overrun;
        logic [31:0]   frames_ok;
        logic [31:0]   frames_bad;
        logic [63:0]   bytes_ok;
        frame_result_t expected_q [$];
        int            mismatches;
        int            bytes_seen;
        int            status_count [4];

        function new();
            frames_ok  = '0;
            frames_bad = '0;
            bytes_ok   = '0;
            mismatches = 0;
            bytes_seen = 0;
            foreach (status_count[i]) status_count[i] = 0;
            start_packet();
        endfunction

        function void start_packet();
            position = 0;
            foreach (header_bytes[i]) header_bytes[i] = 8'h00;
            crc_state = CRC_INIT;
            overrun   = 1'b0;
        endfunction

        // Bit-serial form: feedback is the register LSB xored with the incoming data bit.
        static function logic [31:0] crc_update(logic [31:0] crc, logic [7:0] data);
            logic [31:0] c;
            c = crc;
            for (int i = 0; i < 8; i++) begin
                if (c[0] ^ data[i]) c = {1'b0, c[31:1]} ^ CRC_POLY;
                else c = {1'b0, c[31:1]};
            end
            return c;
        endfunction

        function logic [63:0] le_field(int first, int count);
            logic [63:0] v;
            v = '0;
            for (int i = count - 1; i >= 0; i--) v = {v[55:0], header_bytes[first + i]};
            return v;
        endfunction

        function void note_byte(logic [7:0] data, logic last);
            frame_result_t want;
            frame_status_t status;
            logic [31:0]   declared;
            logic [31:0]   payload;
            bytes_seen++;
            // Bytes past the size limit are neither captured nor hashed.
            if (position >= MAX_PACKET_BYTES) begin
                overrun = 1'b1;
            end else begin
                if (position < HEADER_BYTES) header_bytes[position] = data;
                else crc_state = crc_update(crc_state, data);
                position++;
            end
            if (!last) return;

            want    = '0;
            payload = '0;
            if (position < HEADER_BYTES) begin
                status = STATUS_TOO_SHORT;
            end else begin
                declared = 32'(le_field(32, 4));
                payload  = position - HEADER_BYTES;
                if (overrun || declared != payload) status = STATUS_LEN_MISMATCH;
                else if (~crc_state != 32'(le_field(36, 4))) status = STATUS_CRC_MISMATCH;
                else status = STATUS_ACCEPTED;
            end

            if (status == STATUS_ACCEPTED) begin
                frames_ok++;
                bytes_ok += 64'(position);
                want.image_width    = 32'(le_field(0, 4));
                want.image_height   = 32'(le_field(4, 4));
                want.row_stride     = 32'(le_field(8, 4));
                want.pixel_format   = header_bytes[12];
                want.camera_number  = header_bytes[13];
                want.time_word      = le_field(16, 8);
                want.frame_sequence = le_field(24, 8);
            end else begin
                frames_bad++;
            end
            want.frame_status   = status;
            want.payload_length = payload[15:0];
            want.accepted_total = frames_ok;
            want.dropped_total  = frames_bad;
            want.byte_total     = bytes_ok;
            expected_q.push_back(want);
            start_packet();
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] seen);
            if (seen !== want) begin
                $error("%s: expected %0h, got %0h", field, want, seen);
                mismatches++;
            end
        endfunction

        function void check_result(frame_result_t got);
            frame_result_t want;
            if (expected_q.size() == 0) begin
                $error("frame result with no packet outstanding, status %0d", got.frame_status);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            status_count[want.frame_status]++;
            compare_field("frame_status", want.frame_status, got.frame_status);
            compare_field("image_width", want.image_width, got.image_width);
            compare_field("image_height", want.image_height, got.image_height);
            compare_field("row_stride", want.row_stride, got.row_stride);
            compare_field("pixel_format", want.pixel_format, got.pixel_format);
            compare_field("camera_number", want.camera_number, got.camera_number);
            compare_field("time_word", want.time_word, got.time_word);
            compare_field("frame_sequence", want.frame_sequence, got.frame_sequence);
            compare_field("payload_length", want.payload_length, got.payload_length);
            compare_field("accepted_total", want.accepted_total, got.accepted_total);
            compare_field("dropped_total", want.dropped_total, got.dropped_total);
            compare_field("byte_total", want.byte_total, got.byte_total);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_last_byte;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_frame_status;
    logic [31:0] m_image_width;
    logic [31:0] m_image_height;
    logic [31:0] m_row_stride;
    logic [7:0]  m_pixel_format;
    logic [7:0]  m_camera_number;
    logic [63:0] m_time_word;
    logic [63:0] m_frame_sequence;
    logic [15:0] m_payload_length;
    logic [31:0] m_accepted_total;
    logic [31:0] m_dropped_total;
    logic [63:0] m_byte_total;

    frame_scoreboard sb = new();
    logic [7:0]      frame_q [$];
    bit              quiet_phase;
    int              hold_off_cycles;
    int              input_stall_cycles;

    framed_packet_crc_validator_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_last_byte      (s_last_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_status   (m_frame_status),
        .m_image_width    (m_image_width),
        .m_image_height   (m_image_height),
        .m_row_stride     (m_row_stride),
        .m_pixel_format   (m_pixel_format),
        .m_camera_number  (m_camera_number),
        .m_time_word      (m_time_word),
        .m_frame_sequence (m_frame_sequence),
        .m_payload_length (m_payload_length),
        .m_accepted_total (m_accepted_total),
        .m_dropped_total  (m_dropped_total),
        .m_byte_total     (m_byte_total)
    );

    always #6 aclk = ~aclk;

    initial begin : run_limit
        #(12 * 200_000);
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge aclk) begin : result_monitor
        frame_result_t seen;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                seen.frame_status   = frame_status_t'(m_frame_status);
                seen.image_width    = m_image_width;
                seen.image_height   = m_image_height;
                seen.row_stride     = m_row_stride;
                seen.pixel_format   = m_pixel_format;
                seen.camera_number  = m_camera_number;
                seen.time_word      = m_time_word;
                seen.frame_sequence = m_frame_sequence;
                seen.payload_length = m_payload_length;
                seen.accepted_total = m_accepted_total;
                seen.dropped_total  = m_dropped_total;
                seen.byte_total     = m_byte_total;
                sb.check_result(seen);
            end
            if (s_valid && !s_ready) input_stall_cycles++;
        end
    end

    // Result side: random back-pressure, plus a counted hold-off requested by the stimulus.
    initial begin : result_sink
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_off_cycles > 0) begin
                m_ready <= 1'b0;
                hold_off_cycles--;
            end else begin
                m_ready <= quiet_phase || ($urandom_range(99) >= 20);
            end
        end
    end

    function automatic logic [7:0] fill_byte(fill_t fill);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default:   return 8'($urandom_range(255));
        endcase
    endfunction

    // For a short frame, plen is the whole length; otherwise it is the payload length.
    function automatic void build_frame(frame_kind_t kind, int unsigned plen, fill_t fill);
        logic [31:0] declared;
        logic [31:0] crc;
        logic [7:0]  b;
        frame_q.delete();
        if (kind == KIND_SHORT) begin
            repeat (plen) frame_q.push_back(fill_byte(fill));
            return;
        end
        repeat (HEADER_BYTES) frame_q.push_back(fill_byte(fill));
        crc = CRC_INIT;
        repeat (plen) begin
            b = fill_byte(fill);
            crc = frame_scoreboard::crc_update(crc, b);
            frame_q.push_back(b);
        end
        crc = ~crc;
        declared = plen;
        if (kind == KIND_LEN_ERR) begin
            case ($urandom_range(2))
                0:       declared = plen + 1;
                1:       declared = plen - 1;
                default: declared = $urandom;
            endcase
            if (declared == plen) declared = ~declared;
        end
        if (kind == KIND_CRC_ERR)
            crc ^= $urandom_range(1) ? (32'd1 << $urandom_range(31)) : ($urandom | 32'd1);
        for (int i = 0; i < 4; i++) begin
            frame_q[32 + i] = declared[8*i +: 8];
            frame_q[36 + i] = crc[8*i +: 8];
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_byte(logic [7:0] data, logic last);
        while (!quiet_phase && $urandom_range(99) < 20) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= data;
        s_last_byte <= last;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(s_data_byte, s_last_byte);
        @(negedge aclk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin : stimulus
        int          start_bytes;
        int          frames_sent;
        int          pick;
        int unsigned plen;
        frame_kind_t kind;

        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_data_byte        = 8'h00;
        s_last_byte        = 1'b0;
        quiet_phase        = 1'b0;
        hold_off_cycles    = 0;
        input_stall_cycles = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Boundaries: single byte, one short of a header, empty payloads, constant fills.
        build_frame(KIND_SHORT, 1, FILL_ONES);      send_frame();
        build_frame(KIND_SHORT, 39, FILL_RANDOM);   send_frame();
        build_frame(KIND_GOOD, 0, FILL_ZERO);       send_frame();
        build_frame(KIND_GOOD, 0, FILL_ONES);       send_frame();
        build_frame(KIND_GOOD, 8, FILL_ONES);       send_frame();
        build_frame(KIND_GOOD, 5, FILL_ZERO);       send_frame();
        build_frame(KIND_LEN_ERR, 3, FILL_RANDOM);  send_frame();
        build_frame(KIND_CRC_ERR, 12, FILL_RANDOM); send_frame();
        build_frame(KIND_GOOD, 41, FILL_RANDOM);    send_frame();
        wait_for_results();

        // Stall the result side while tiny packets pile up behind the result register.
        hold_off_cycles = 300;
        repeat (10) begin
            build_frame(KIND_SHORT, $urandom_range(1, 3), FILL_RANDOM);
            send_frame();
        end
        build_frame(KIND_GOOD, 6, FILL_RANDOM);
        send_frame();
        wait_for_results();

        start_bytes = sb.bytes_seen;
        frames_sent = 0;
        while (sb.bytes_seen < start_bytes + 550 || frames_sent < 10) begin
            quiet_phase = (frames_sent >= 3 && frames_sent < 8);
            pick = $urandom_range(99);
            if (pick < 55) kind = KIND_GOOD;
            else if (pick < 70) kind = KIND_CRC_ERR;
            else if (pick < 85) kind = KIND_LEN_ERR;
            else kind = KIND_SHORT;
            pick = $urandom_range(99);
            if (kind == KIND_SHORT) plen = $urandom_range(1, 39);
            else if (pick < 85) plen = $urandom_range(24);
            else plen = $urandom_range(25, 120);
            build_frame(kind, plen, FILL_RANDOM);
            send_frame();
            frames_sent++;
        end
        quiet_phase = 1'b0;
        wait_for_results();
        repeat (20) @(posedge aclk);

        if (sb.expected_q.size() != 0) begin
            $error("%0d frame results never arrived", sb.expected_q.size());
            sb.mismatches++;
        end
        $display("Checked %0d frames from %0d words: %0d accepted, %0d short,",
                 sb.frames_ok + sb.frames_bad, sb.bytes_seen, sb.status_count[STATUS_ACCEPTED],
                 sb.status_count[STATUS_TOO_SHORT]);
        $display("%0d bad length, %0d bad CRC; input held off for %0d cycles by back-pressure",
                 sb.status_count[STATUS_LEN_MISMATCH], sb.status_count[STATUS_CRC_MISMATCH],
                 input_stall_cycles);
        if (sb.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
